// ----- rtl/sha1s_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1s_pkg
// Shared types, constants and round helpers for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1s_pkg;

	// Five chaining words, H0 in element 0
	typedef logic [4:0][31:0] hash_t;

	// One compression job: which buffer bank, how many message bytes it
	// holds, and which padding pieces the core overlays on the read data
	typedef struct packed {
		logic       bank;
		logic [6:0] nbytes;
		logic       pad80;
		logic       put_len;
	} job_t;

	localparam logic [31:0] H_INIT [5] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_ROUND [4] = '{
		32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
	};

	localparam logic [7:0] PAD_BYTE     = 8'h80;
	localparam logic [6:0] BLOCK_BYTES  = 7'd64;
	localparam logic [6:0] LEN_OFFSET   = 7'd56;
	localparam logic [6:0] LAST_ROUND   = 7'd79;

	// Round constant by round number
	function automatic logic [31:0] round_k(input logic [6:0] rnd);
		logic [31:0] k;
		if (rnd < 7'd20) begin
			k = K_ROUND[0];
		end else if (rnd < 7'd40) begin
			k = K_ROUND[1];
		end else if (rnd < 7'd60) begin
			k = K_ROUND[2];
		end else begin
			k = K_ROUND[3];
		end
		return k;
	endfunction

	// Boolean function: choose, parity, majority, parity
	function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (rnd < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (rnd < 7'd40 || rnd >= 7'd60) begin
			f = b ^ c ^ d;
		end else begin
			f = (b & c) | (b & d) | (c & d);
		end
		return f;
	endfunction

	// Overlay padding on a buffer word: message bytes below nbytes, 0x80 at
	// nbytes if pad80, bit length in words 14 and 15 if put_len, zero elsewhere
	function automatic logic [31:0] pad_word(input logic [31:0] data, input logic [3:0] j,
			input job_t job, input logic [63:0] len_bits);
		logic [31:0] lw;
		logic [31:0] r;
		logic [6:0]  p;
		lw = j[0] ? len_bits[31:0] : len_bits[63:32];
		r  = '0;
		for (int k = 0; k < 4; k++) begin
			p = {1'b0, j, 2'(k)};
			if (p < job.nbytes) begin
				r[31-8*k -: 8] = data[31-8*k -: 8];
			end else if (job.pad80 && p == job.nbytes) begin
				r[31-8*k -: 8] = PAD_BYTE;
			end else if (job.put_len && p >= LEN_OFFSET) begin
				r[31-8*k -: 8] = lw[31-8*k -: 8];
			end else begin
				r[31-8*k -: 8] = 8'h00;
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/sha1s_buffer.sv -----
// ----------------------------------------------------------------------------
// sha1s_buffer
// Two-bank block buffer, 32 words of 32 bits, big-endian byte lanes.
// Byte writes on one port, registered word reads on the other.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_buffer (
	input  wire logic        clk,
	input  wire logic        wr_en,
	input  wire logic [4:0]  wr_addr,
	input  wire logic [1:0]  wr_lane,
	input  wire logic [7:0]  wr_byte,
	input  wire logic        rd_en,
	input  wire logic [4:0]  rd_addr,
	output logic      [31:0] rd_data
);

	logic [3:0][7:0] mem [32];

	// Byte write: lane 0 is the most significant byte of the word
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr][2'd3 - wr_lane] <= wr_byte;
		end
	end

	// Registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sha1s_core.sv -----
// ----------------------------------------------------------------------------
// sha1s_core
// SHA-1 compression engine: one round per cycle, schedule in a 16-word
// shift line, first 16 words read from the block buffer with padding overlay.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sha1s_pkg::job_t   job,
	input  wire logic [63:0]       len_bits,
	input  wire logic              init,
	output logic                   busy,
	output logic                   rd_en,
	output logic [4:0]             rd_addr,
	input  wire logic [31:0]       rd_data,
	output sha1s_pkg::hash_t       hash
);

	typedef enum logic [1:0] {
		C_IDLE,
		C_PRIME,
		C_ROUND,
		C_ADD
	} cstate_t;

	cstate_t             st_q;
	logic [6:0]          rnd_q;
	sha1s_pkg::job_t     job_q;
	sha1s_pkg::hash_t    h_q;
	logic [31:0]         a_q, b_q, c_q, d_q, e_q;
	logic [15:0][31:0]   w_q;

	logic [31:0] w_sched;
	logic [31:0] w_cur;
	logic [31:0] nv;

	assign busy = (st_q != C_IDLE);
	assign hash = h_q;

	// Buffer read: word 0 while priming, word r+1 during rounds 0 to 14
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = {job_q.bank, 4'd0};
		case (st_q)
			C_PRIME: begin
				rd_en = 1'b1;
			end
			C_ROUND: begin
				rd_en   = (rnd_q < 7'd15);
				rd_addr = {job_q.bank, rnd_q[3:0] + 4'd1};
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Schedule word: taps r-3, r-8, r-14, r-16 of the shift line
	assign w_sched = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_cur   = (rnd_q < 7'd16)
		? sha1s_pkg::pad_word(rd_data, rnd_q[3:0], job_q, len_bits)
		: {w_sched[30:0], w_sched[31]};

	// Round sum
	assign nv = {a_q[26:0], a_q[31:27]} + sha1s_pkg::round_f(rnd_q, b_q, c_q, d_q)
		+ e_q + sha1s_pkg::round_k(rnd_q) + w_cur;

	// Sequencer, working variables and chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= C_IDLE;
			rnd_q <= '0;
			job_q <= '0;
			for (int i = 0; i < 5; i++) begin
				h_q[i] <= sha1s_pkg::H_INIT[i];
			end
		end else begin
			case (st_q)
				C_IDLE: begin
					if (init) begin
						for (int i = 0; i < 5; i++) begin
							h_q[i] <= sha1s_pkg::H_INIT[i];
						end
					end else if (start) begin
						job_q <= job;
						a_q   <= h_q[0];
						b_q   <= h_q[1];
						c_q   <= h_q[2];
						d_q   <= h_q[3];
						e_q   <= h_q[4];
						st_q  <= C_PRIME;
					end
				end
				C_PRIME: begin
					rnd_q <= '0;
					st_q  <= C_ROUND;
				end
				C_ROUND: begin
					w_q <= {w_cur, w_q[15:1]};
					a_q <= nv;
					b_q <= a_q;
					c_q <= {b_q[1:0], b_q[31:2]};
					d_q <= c_q;
					e_q <= d_q;
					if (rnd_q == sha1s_pkg::LAST_ROUND) begin
						st_q <= C_ADD;
					end else begin
						rnd_q <= rnd_q + 7'd1;
					end
				end
				C_ADD: begin
					h_q[0] <= h_q[0] + a_q;
					h_q[1] <= h_q[1] + b_q;
					h_q[2] <= h_q[2] + c_q;
					h_q[3] <= h_q[3] + d_q;
					h_q[4] <= h_q[4] + e_q;
					st_q   <= C_IDLE;
				end
				default: begin
					st_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sha1_stream_hasher.sv -----
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// Byte-serial SHA-1: one byte per beat, 64-byte blocks in a two-bank buffer.
// Bytes are taken one per cycle while in_ready is high; a block compresses (read prime,
// 80 rounds, chaining add) while the next block fills the other bank.
// A byte that completes a block stalls while the previous block still runs.
// End of message: one or two padded compressions, then five
// digest beats. Asynchronous reset loads the SHA-1 initial chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        end_of_message,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	typedef enum logic [2:0] {
		S_RUN,
		S_FIN,
		S_FIN2,
		S_WAIT,
		S_OUT
	} state_t;

	state_t            st_q;
	logic [5:0]        fill_q;
	logic              bank_q;
	logic [60:0]       len_q;

	logic              in_acc;
	logic              out_acc;
	logic              blk_done;
	logic              start;
	logic              init;
	sha1s_pkg::job_t   job;
	logic              core_busy;
	logic              rd_en;
	logic [4:0]        rd_addr;
	logic [31:0]       rd_data;
	sha1s_pkg::hash_t  hash;

	assign blk_done = byte_valid && (fill_q == 6'd63);
	assign in_ready = (st_q == S_RUN) && !(core_busy && blk_done);
	assign in_acc   = in_valid && in_ready;
	assign out_acc  = out_valid && out_ready;
	assign init     = out_acc && last_word;

	// Compression launch and job description
	always_comb begin
		start = 1'b0;
		job   = '{bank: bank_q, nbytes: sha1s_pkg::BLOCK_BYTES, pad80: 1'b0, put_len: 1'b0};
		case (st_q)
			S_RUN: begin
				start = in_acc && blk_done;
			end
			S_FIN: begin
				start = !core_busy;
				job   = '{bank: bank_q, nbytes: {1'b0, fill_q}, pad80: 1'b1,
					put_len: ({1'b0, fill_q} < sha1s_pkg::LEN_OFFSET)};
			end
			S_FIN2: begin
				start = !core_busy;
				job   = '{bank: bank_q, nbytes: 7'd0, pad80: 1'b0, put_len: 1'b1};
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	// Control and digest output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_RUN;
			fill_q      <= '0;
			bank_q      <= 1'b0;
			len_q       <= '0;
			out_valid   <= 1'b0;
			digest_word <= '0;
			word_index  <= '0;
			last_word   <= 1'b0;
		end else begin
			case (st_q)
				S_RUN: begin
					if (in_acc) begin
						if (byte_valid) begin
							len_q  <= len_q + 61'd1;
							fill_q <= fill_q + 6'd1;
							if (blk_done) begin
								bank_q <= !bank_q;
							end
						end
						if (end_of_message) begin
							st_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (!core_busy) begin
						st_q <= ({1'b0, fill_q} < sha1s_pkg::LEN_OFFSET) ? S_WAIT : S_FIN2;
					end
				end
				S_FIN2: begin
					if (!core_busy) begin
						st_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (!core_busy) begin
						st_q        <= S_OUT;
						out_valid   <= 1'b1;
						digest_word <= hash[0];
						word_index  <= 3'd0;
						last_word   <= 1'b0;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						if (last_word) begin
							out_valid <= 1'b0;
							st_q      <= S_RUN;
							fill_q    <= '0;
							len_q     <= '0;
						end else begin
							digest_word <= hash[word_index + 3'd1];
							word_index  <= word_index + 3'd1;
							last_word   <= (word_index == 3'd3);
						end
					end
				end
				default: begin
					st_q <= S_RUN;
				end
			endcase
		end
	end

	sha1s_buffer u_buf (
		.clk     (clk),
		.wr_en   (in_acc && byte_valid),
		.wr_addr ({bank_q, fill_q[5:2]}),
		.wr_lane (fill_q[1:0]),
		.wr_byte (data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	sha1s_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.job      (job),
		.len_bits ({len_q, 3'b000}),
		.init     (init),
		.busy     (core_busy),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.hash     (hash)
	);

endmodule

`default_nettype wire

// ----- rtl/sha1s_checker.sv -----
// ----------------------------------------------------------------------------
// sha1s_checker
// Port-level checks on the digest beats of the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1s_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_ready,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic [31:0] digest_word,
	input  wire logic [2:0]  word_index,
	input  wire logic        last_word
);

	// A stalled digest beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(digest_word)
			&& $stable(word_index) && $stable(last_word))
		else $error("digest beat changed while stalled");

	// No input taken while the digest is being delivered
	a_no_in_during_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready during digest output");

	// A digest starts at word 0
	a_first_word: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> word_index == 3'd0)
		else $error("digest does not start at word 0");

	// Words follow in order
	a_word_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_word |=> out_valid
			&& word_index == $past(word_index) + 3'd1)
		else $error("digest word sequence broken");

	// Nothing more after the last word
	a_last_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && last_word |=> !out_valid)
		else $error("extra beat after last digest word");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (.*);

`default_nettype wire
